// ----- design/wapt_pkg.sv -----
`default_nettype none

package wapt_pkg;

   localparam int WINDOW_DEFAULT      = 64;
   localparam int SAMPLE_BITS_DEFAULT = 32;
   localparam int FRAC_BITS_DEFAULT   = 8;

   typedef struct packed {
      logic capture;
      logic update;
      logic div_start;
      logic div_step;
      logic out_load;
   } wapt_cmd_type;

   typedef struct packed {
      logic div_done;
   } wapt_status_type;

endpackage

`default_nettype wire

// ----- design/wapt_ctrl.sv -----
`default_nettype none

module wapt_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output wapt_pkg::wapt_cmd_type         cmd,
   input  wire wapt_pkg::wapt_status_type status
);
   import wapt_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_UPDATE,
      S_LOAD,
      S_DIVIDE,
      S_DONE
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd           = '0;
      cmd.capture   = (state_ff == S_IDLE) && req_valid;
      cmd.update    = (state_ff == S_UPDATE);
      cmd.div_start = (state_ff == S_LOAD);
      cmd.div_step  = (state_ff == S_DIVIDE) && !status.div_done;
      cmd.out_load  = (state_ff == S_DONE) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_UPDATE;
               end
            end
            S_UPDATE: begin
               state_ff <= S_LOAD;
            end
            S_LOAD: begin
               state_ff <= S_DIVIDE;
            end
            S_DIVIDE: begin
               if (status.div_done) begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over a beat that was not taken");

   a_accept_goes_update: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_UPDATE))
      else $error("accepted beat did not start an update");

   a_valid_after_load: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid_ff)
      else $error("loaded result not presented");

endmodule

`default_nettype wire

// ----- design/wapt_datapath.sv -----
`default_nettype none

module wapt_datapath #(
   parameter int WINDOW      = wapt_pkg::WINDOW_DEFAULT,
   parameter int SAMPLE_BITS = wapt_pkg::SAMPLE_BITS_DEFAULT,
   parameter int FRAC_BITS   = wapt_pkg::FRAC_BITS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire wapt_pkg::wapt_cmd_type              cmd,
   output wapt_pkg::wapt_status_type                status,
   input  wire logic [SAMPLE_BITS-1:0]              req_sample,
   output logic [SAMPLE_BITS+FRAC_BITS-1:0]         rsp_mean_fixed,
   output logic [SAMPLE_BITS-1:0]                   rsp_peak,
   output logic [$clog2(WINDOW+1)-1:0]              rsp_fill_count
);
   import wapt_pkg::*;

   localparam int CNT_BITS  = $clog2(WINDOW + 1);
   localparam int SLOT_BITS = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int SUM_BITS  = SAMPLE_BITS + $clog2(WINDOW);
   localparam int DVD_BITS  = SUM_BITS + FRAC_BITS;
   localparam int MEAN_BITS = SAMPLE_BITS + FRAC_BITS;
   localparam int STEP_BITS = $clog2(DVD_BITS + 1);

   logic [SAMPLE_BITS-1:0] ring [WINDOW];
   logic [SAMPLE_BITS-1:0] old_ff;
   logic [SAMPLE_BITS-1:0] sample_ff;
   logic [SLOT_BITS-1:0]   slot_ff;
   logic [CNT_BITS-1:0]    count_ff;
   logic [SUM_BITS-1:0]    sum_ff;
   logic [SUM_BITS-1:0]    sum_in;
   logic [SAMPLE_BITS-1:0] peak_ff;
   logic [DVD_BITS-1:0]    dvd_ff;
   logic [CNT_BITS-1:0]    rem_ff;
   logic [STEP_BITS-1:0]   step_ff;
   logic [CNT_BITS:0]      trial;
   logic                   trial_ok;
   logic                   full;
   logic [MEAN_BITS-1:0]   mean_ff;
   logic [SAMPLE_BITS-1:0] peak_out_ff;
   logic [CNT_BITS-1:0]    fill_out_ff;

   assign full     = (count_ff == CNT_BITS'(WINDOW));
   assign sum_in   = sum_ff - (full ? SUM_BITS'(old_ff) : '0) + SUM_BITS'(sample_ff);
   assign trial    = {rem_ff, dvd_ff[DVD_BITS-1]};
   assign trial_ok = (trial >= (CNT_BITS+1)'(count_ff));

   assign status.div_done = (step_ff == '0);

   always_ff @(posedge clock) begin
      old_ff <= ring[slot_ff];
      if (cmd.update) begin
         ring[slot_ff] <= sample_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff  <= '0;
         count_ff <= '0;
         sum_ff   <= '0;
         peak_ff  <= '0;
         step_ff  <= '0;
      end else begin
         if (cmd.update) begin
            sum_ff <= sum_in;
            if (!full) begin
               count_ff <= count_ff + 1'b1;
            end
            if (slot_ff == SLOT_BITS'(WINDOW - 1)) begin
               slot_ff <= '0;
            end else begin
               slot_ff <= slot_ff + 1'b1;
            end
            if (sample_ff > peak_ff) begin
               peak_ff <= sample_ff;
            end
         end
         if (cmd.div_start) begin
            step_ff <= STEP_BITS'(DVD_BITS);
         end else if (cmd.div_step) begin
            step_ff <= step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sample_ff <= req_sample;
      end
      if (cmd.div_start) begin
         dvd_ff <= DVD_BITS'(sum_ff) << FRAC_BITS;
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         dvd_ff <= {dvd_ff[DVD_BITS-2:0], trial_ok};
         if (trial_ok) begin
            rem_ff <= CNT_BITS'(trial - (CNT_BITS+1)'(count_ff));
         end else begin
            rem_ff <= trial[CNT_BITS-1:0];
         end
      end
      if (cmd.out_load) begin
         mean_ff     <= dvd_ff[MEAN_BITS-1:0];
         peak_out_ff <= peak_ff;
         fill_out_ff <= count_ff;
      end
   end

   assign rsp_mean_fixed = mean_ff;
   assign rsp_peak       = peak_out_ff;
   assign rsp_fill_count = fill_out_ff;

   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> (count_ff != '0))
      else $error("division started with an empty window");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(WINDOW))
      else $error("fill count beyond the window");

   a_peak_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (peak_ff >= $past(peak_ff)))
      else $error("peak decreased");

   a_mean_below_peak: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (dvd_ff <= (DVD_BITS'(peak_ff) << FRAC_BITS)))
      else $error("mean exceeds the peak");

endmodule

`default_nettype wire

// ----- design/windowed_average_peak_tracker_core.sv -----
// rsp_valid rises once the one-bit-per-cycle restoring divider has finished and the result
// is loaded into the output register; the controller steps IDLE, UPDATE, LOAD, DIVIDE, DONE.
// A new beat is taken only in IDLE, never while the previous one is still being processed;
// the next beat may be taken while the previous result still waits in the output register.
// Reset clears the controller, fill count, write slot, running sum and peak at once.
// The sample ring is not cleared; entries are only read after they are written.
`default_nettype none

module windowed_average_peak_tracker_core #(
   parameter int WINDOW      = wapt_pkg::WINDOW_DEFAULT,
   parameter int SAMPLE_BITS = wapt_pkg::SAMPLE_BITS_DEFAULT,
   parameter int FRAC_BITS   = wapt_pkg::FRAC_BITS_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [SAMPLE_BITS-1:0]      req_sample,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [SAMPLE_BITS+FRAC_BITS-1:0] rsp_mean_fixed,
   output logic [SAMPLE_BITS-1:0]           rsp_peak,
   output logic [$clog2(WINDOW+1)-1:0]      rsp_fill_count
);
   import wapt_pkg::*;

   wapt_cmd_type    cmd;
   wapt_status_type status;

   wapt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   wapt_datapath #(
      .WINDOW      (WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS),
      .FRAC_BITS   (FRAC_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_sample     (req_sample),
      .rsp_mean_fixed (rsp_mean_fixed),
      .rsp_peak       (rsp_peak),
      .rsp_fill_count (rsp_fill_count)
   );

endmodule

`default_nettype wire
